// ===== rtl/sri_pkg.sv =====
// Shared constants and widths for the stratified resampling index block.
package sri_pkg;

    // Sizing
    localparam int MAX_PARTICLES = 128;
    localparam int FRAC_BITS     = 16;

    localparam int PTR_W     = $clog2(MAX_PARTICLES);
    localparam int CNT_W     = $clog2(MAX_PARTICLES + 1);
    localparam int WEIGHT_W  = 16;
    localparam int UNIFORM_W = 16;
    localparam int SUM_W     = 24;
    localparam int INDEX_W   = 7;
    localparam int CFG_W     = 8;

    localparam int TGT_W  = PTR_W + FRAC_BITS;
    localparam int PROD_W = CNT_W + SUM_W;
    localparam int CMP_W  = (TGT_W > PROD_W) ? TGT_W : PROD_W;
    localparam int RAM_W  = WEIGHT_W + SUM_W;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_PARTICLE_COUNT = 3'd0;
    localparam logic [CFG_W-1:0]      PARTICLE_COUNT_RST  = 8'd100;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

endpackage

// ===== rtl/sri_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sri_cmp_unit.sv =====
// Shared scale-and-compare unit: registers N * cumsum, then tests target < product.
module sri_cmp_unit (
    input  logic                      i_clk,
    input  logic                      i_mul_en,
    input  logic [sri_pkg::CNT_W-1:0] i_n,
    input  logic [sri_pkg::SUM_W-1:0] i_cum,
    input  logic [sri_pkg::TGT_W-1:0] i_target,
    output logic                      o_lt
);

    logic [sri_pkg::PROD_W-1:0] r_prod;
    logic [sri_pkg::PROD_W-1:0] n_prod;

    // Scale the cumulative sum by the particle count
    assign n_prod = sri_pkg::PROD_W'(i_n) * sri_pkg::PROD_W'(i_cum);

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= n_prod;
        end
    end

    // Compare the stratified target against the registered product
    assign o_lt = sri_pkg::CMP_W'(i_target) < sri_pkg::CMP_W'(r_prod);

endmodule

// ===== rtl/stratified_resampling_index_top.sv =====
// Top level: round state, walk sequencer, config register and output register.
// A load item is taken in ST_IDLE; the block stays ready for the next item.
// A draw item probes one stored entry at a time (RAM read, multiply, compare);
// it goes straight to ST_EMIT when nothing is loaded, and the input stays
// stalled until the result enters the output register.
// Synchronous active-low reset clears the round state and sets particle_count to 100.
module stratified_resampling_index_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [sri_pkg::WEIGHT_W-1:0]        i_weight,
    input  logic [sri_pkg::UNIFORM_W-1:0]       i_uniform,
    // Result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sri_pkg::INDEX_W-1:0]         o_index,
    output logic [sri_pkg::WEIGHT_W-1:0]        o_weight_out,
    output logic                                o_last,
    output logic                                o_overrun,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sri_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sri_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sri_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_CMP,
        ST_EMIT
    } t_state_e;

    t_state_e r_state, n_state;

    logic [sri_pkg::CFG_W-1:0]    r_particle_count, n_particle_count;
    logic [sri_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [sri_pkg::CNT_W-1:0]    r_load_ptr, n_load_ptr;
    logic [sri_pkg::PTR_W-1:0]    r_draw_cnt, n_draw_cnt;
    logic [sri_pkg::PTR_W-1:0]    r_walk, n_walk;
    logic [sri_pkg::PTR_W-1:0]    r_j, n_j;
    logic [sri_pkg::TGT_W-1:0]    r_target, n_target;
    logic [sri_pkg::WEIGHT_W-1:0] r_wsel, n_wsel;
    logic                         r_over, n_over;
    logic                         r_has_entries, n_has_entries;

    logic                         r_out_valid, n_out_valid;
    logic [sri_pkg::INDEX_W-1:0]  r_out_index, n_out_index;
    logic [sri_pkg::WEIGHT_W-1:0] r_out_weight, n_out_weight;
    logic                         r_out_last, n_out_last;
    logic                         r_out_over, n_out_over;

    logic                         in_accept;
    logic                         cfg_wr;
    logic [sri_pkg::CNT_W-1:0]    n_eff;
    logic                         load_ok;
    logic [sri_pkg::PTR_W-1:0]    last_idx;
    logic [sri_pkg::SUM_W:0]      sum_ext;
    logic [sri_pkg::SUM_W-1:0]    sum_sat;
    logic                         is_last;
    logic                         slot_free;
    logic                         ram_wr_en;
    logic [sri_pkg::RAM_W-1:0]    ram_rd_data;
    logic [sri_pkg::SUM_W-1:0]    rd_cum;
    logic [sri_pkg::WEIGHT_W-1:0] rd_weight;
    logic                         lt;

    // Handshakes
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite && pready
                        && (paddr == sri_pkg::ADDR_PARTICLE_COUNT);
    assign pready     = 1'b1;
    assign prdata     = (paddr == sri_pkg::ADDR_PARTICLE_COUNT)
                        ? sri_pkg::APB_DATA_W'(r_particle_count) : '0;

    // Clamp the particle count to 1..MAX_PARTICLES
    always_comb begin
        if (r_particle_count == '0) begin
            n_eff = sri_pkg::CNT_W'(1);
        end else if (32'(r_particle_count) > sri_pkg::MAX_PARTICLES) begin
            n_eff = sri_pkg::CNT_W'(sri_pkg::MAX_PARTICLES);
        end else begin
            n_eff = sri_pkg::CNT_W'(r_particle_count);
        end
    end

    assign load_ok  = r_load_ptr < n_eff;
    assign last_idx = sri_pkg::PTR_W'(r_load_ptr - sri_pkg::CNT_W'(1));
    assign is_last  = (sri_pkg::CNT_W'(r_draw_cnt) + sri_pkg::CNT_W'(1)) >= n_eff;

    // Saturating running sum
    assign sum_ext = {1'b0, r_sum} + (sri_pkg::SUM_W + 1)'(i_weight);
    assign sum_sat = sum_ext[sri_pkg::SUM_W] ? sri_pkg::SUM_MAX : sum_ext[sri_pkg::SUM_W-1:0];

    assign ram_wr_en = in_accept && (i_func == sri_pkg::FUNC_LOAD) && load_ok;
    assign rd_weight = ram_rd_data[sri_pkg::RAM_W-1 -: sri_pkg::WEIGHT_W];
    assign rd_cum    = ram_rd_data[sri_pkg::SUM_W-1:0];

    assign slot_free = !r_out_valid || !i_out_stall;

    // Weight and cumulative sum store
    sri_ram #(
        .WIDTH (sri_pkg::RAM_W),
        .DEPTH (sri_pkg::MAX_PARTICLES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (sri_pkg::PTR_W'(r_load_ptr)),
        .i_wr_data ({i_weight, sum_sat}),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (r_j),
        .o_rd_data (ram_rd_data)
    );

    // Shared scale and compare unit
    sri_cmp_unit u_cmp (
        .i_clk    (i_clk),
        .i_mul_en (r_state == ST_MUL),
        .i_n      (n_eff),
        .i_cum    (rd_cum),
        .i_target (r_target),
        .o_lt     (lt)
    );

    // Next-state logic for the sequencer and round state
    always_comb begin
        n_state          = r_state;
        n_particle_count = r_particle_count;
        n_sum            = r_sum;
        n_load_ptr       = r_load_ptr;
        n_draw_cnt       = r_draw_cnt;
        n_walk           = r_walk;
        n_j              = r_j;
        n_target         = r_target;
        n_wsel           = r_wsel;
        n_over           = r_over;
        n_has_entries    = r_has_entries;
        n_out_valid      = r_out_valid;
        n_out_index      = r_out_index;
        n_out_weight     = r_out_weight;
        n_out_last       = r_out_last;
        n_out_over       = r_out_over;

        if (cfg_wr) begin
            n_particle_count = pwdata[sri_pkg::CFG_W-1:0];
        end

        // Drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_func == sri_pkg::FUNC_LOAD) begin
                        if (load_ok) begin
                            n_sum      = sum_sat;
                            n_load_ptr = r_load_ptr + sri_pkg::CNT_W'(1);
                        end
                    end else begin
                        n_target = {r_draw_cnt, sri_pkg::FRAC_BITS'(i_uniform)};
                        if (r_load_ptr == '0) begin
                            n_j           = '0;
                            n_wsel        = '0;
                            n_over        = 1'b1;
                            n_has_entries = 1'b0;
                            n_state       = ST_EMIT;
                        end else begin
                            n_j           = (r_walk > last_idx) ? last_idx : r_walk;
                            n_has_entries = 1'b1;
                            n_state       = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_wsel  = rd_weight;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // Advance the walk until the target falls below the scaled sum; past the last entry, flag overrun
                if (lt) begin
                    n_over  = 1'b0;
                    n_state = ST_EMIT;
                end else if (r_j < last_idx) begin
                    n_j     = r_j + sri_pkg::PTR_W'(1);
                    n_state = ST_READ;
                end else begin
                    n_over  = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = sri_pkg::INDEX_W'(r_j);
                    n_out_weight = r_wsel;
                    n_out_last   = is_last;
                    n_out_over   = r_over;
                    if (is_last) begin
                        n_sum      = '0;
                        n_load_ptr = '0;
                        n_draw_cnt = '0;
                        n_walk     = '0;
                    end else begin
                        n_draw_cnt = r_draw_cnt + sri_pkg::PTR_W'(1);
                        if (r_has_entries) begin
                            n_walk = r_j;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_particle_count <= sri_pkg::PARTICLE_COUNT_RST;
            r_sum            <= '0;
            r_load_ptr       <= '0;
            r_draw_cnt       <= '0;
            r_walk           <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_particle_count <= n_particle_count;
            r_sum            <= n_sum;
            r_load_ptr       <= n_load_ptr;
            r_draw_cnt       <= n_draw_cnt;
            r_walk           <= n_walk;
            r_out_valid      <= n_out_valid;
        end
        r_j           <= n_j;
        r_target      <= n_target;
        r_wsel        <= n_wsel;
        r_over        <= n_over;
        r_has_entries <= n_has_entries;
        r_out_index   <= n_out_index;
        r_out_weight  <= n_out_weight;
        r_out_last    <= n_out_last;
        r_out_over    <= n_out_over;
    end

    assign o_out_valid  = r_out_valid;
    assign o_index      = r_out_index;
    assign o_weight_out = r_out_weight;
    assign o_last       = r_out_last;
    assign o_overrun    = r_out_over;

endmodule
